### hw/rtl/q8sf_pkg.sv
// ----------------------------------------------------------------------------
// q8sf_pkg
// Widths, node codes and arithmetic helpers for the Quad8 shape function
// evaluator.
// ----------------------------------------------------------------------------
package q8sf_pkg;

  localparam int FRAC_BITS = 14;
  localparam int COORD_W   = 16;   // input coordinate, Q1.14
  localparam int FACT_W    = 18;   // signed factor, magnitude up to 3.0
  localparam int MAG_W     = 16;   // factor magnitude
  localparam int PROD_W    = 2 * MAG_W;
  localparam int FULL_W    = PROD_W + MAG_W;
  localparam int OUT_W     = 17;   // Q2.14 result
  localparam int RND_W     = 20;   // rounded magnitude before saturation
  localparam int SH_W      = 6;
  localparam int NODE_W    = 3;
  localparam int TERMS     = 3;    // value, d/dxi, d/deta

  localparam logic signed [FACT_W-1:0] ONE = FACT_W'(1) <<< FRAC_BITS;
  localparam logic [RND_W-1:0] SAT_POS     = RND_W'((1 << (OUT_W - 1)) - 1);
  localparam logic [RND_W-1:0] SAT_NEG_MAG = RND_W'(1 << (OUT_W - 1));

  // node codes, counterclockwise from (-1,-1)
  localparam logic [NODE_W-1:0] N_SW = 3'd0;
  localparam logic [NODE_W-1:0] N_S  = 3'd1;
  localparam logic [NODE_W-1:0] N_SE = 3'd2;
  localparam logic [NODE_W-1:0] N_E  = 3'd3;
  localparam logic [NODE_W-1:0] N_NE = 3'd4;
  localparam logic [NODE_W-1:0] N_N  = 3'd5;
  localparam logic [NODE_W-1:0] N_NW = 3'd6;
  localparam logic [NODE_W-1:0] N_W  = 3'd7;
  localparam logic [NODE_W-1:0] N_FIRST = N_SW;
  localparam logic [NODE_W-1:0] N_LAST  = N_W;

  typedef struct packed {
    logic             neg;
    logic [1:0]       k;
    logic [MAG_W-1:0] ma;
    logic [MAG_W-1:0] mb;
    logic [MAG_W-1:0] mc;
  } term_t;

  typedef struct packed {
    logic              neg;
    logic [1:0]        k;
    logic [PROD_W-1:0] p;
    logic [MAG_W-1:0]  mc;
  } prod_t;

  typedef struct packed {
    logic              neg;
    logic [1:0]        k;
    logic [FULL_W-1:0] q;
  } full_t;

  function automatic logic signed [COORD_W-1:0] clamp_coord(
    logic signed [COORD_W-1:0] v
  );
    logic signed [FACT_W-1:0] w;
    logic signed [FACT_W-1:0] r;
    w = FACT_W'(v);
    if (w > ONE) begin
      r = ONE;
    end else if (w < -ONE) begin
      r = -ONE;
    end else begin
      r = w;
    end
    return r[COORD_W-1:0];
  endfunction

  function automatic logic [MAG_W-1:0] mag(logic signed [FACT_W-1:0] v);
    logic signed [FACT_W-1:0] a;
    a = v[FACT_W-1] ? -v : v;
    return a[MAG_W-1:0];
  endfunction

  // sign and magnitudes of neg * a * b * c / 2^(2*frac + k)
  function automatic term_t make_term(
    logic neg, logic [1:0] k,
    logic signed [FACT_W-1:0] a,
    logic signed [FACT_W-1:0] b,
    logic signed [FACT_W-1:0] c
  );
    term_t t;
    t.neg = neg ^ a[FACT_W-1] ^ b[FACT_W-1] ^ c[FACT_W-1];
    t.k   = k;
    t.ma  = mag(a);
    t.mb  = mag(b);
    t.mc  = mag(c);
    return t;
  endfunction

  // round half away from zero on the magnitude, saturate, apply sign
  function automatic logic signed [OUT_W-1:0] round_term(full_t f);
    logic [SH_W-1:0]   sh;
    logic [FULL_W-1:0] half;
    logic [FULL_W-1:0] sum;
    logic [RND_W-1:0]  r;
    logic [RND_W-1:0]  m;
    logic [RND_W-1:0]  neg_m;
    sh   = SH_W'(2 * FRAC_BITS) + SH_W'(f.k);
    half = FULL_W'(1) << (sh - SH_W'(1));
    sum  = f.q + half;
    r    = RND_W'(sum >> sh);
    if (f.neg) begin
      m = (r > SAT_NEG_MAG) ? SAT_NEG_MAG : r;
    end else begin
      m = (r > SAT_POS) ? SAT_POS : r;
    end
    neg_m = -m;
    return f.neg ? neg_m[OUT_W-1:0] : m[OUT_W-1:0];
  endfunction

endpackage

### hw/rtl/quad8_shape_function_eval_top.sv
// ----------------------------------------------------------------------------
// quad8_shape_function_eval_top
// Serendipity Quad8 shape functions and their xi/eta derivatives at one point.
// ----------------------------------------------------------------------------
// One point (xi, eta) in Q1.14 goes in per transaction and eight results come
// out, one per node in order 0..7, with tlast on node 7. Coordinates beyond
// +-1.0 are clamped. The node sequencer issues one node a cycle into the
// datapath while the output is not held, and results leave at one per cycle
// on the same condition. The datapath is factor select, first multiply,
// second multiply, then round and saturate into the output register; each
// node leaves the sequencer and passes through these registers in that order.
// The next point is taken in the cycle that node 7 is issued, and a held
// output stalls the whole pipeline without loss.
module quad8_shape_function_eval_top
  import q8sf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // xi_coord[15:0], eta_coord[31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // shape_value[16:0], deriv_xi[33:17],
                                      // deriv_eta[50:34], zero fill
  output logic [2:0]  m_axis_tuser,   // node_index[2:0]
  output logic        m_axis_tlast
);

  // sequencer
  logic                      busy_q, busy_d;
  logic [NODE_W-1:0]         cnt_q, cnt_d;
  logic signed [COORD_W-1:0] x_q, y_q;
  logic                      adv, issue, last_issue, accept;

  // pipeline
  logic                      v1_q, v2_q, v3_q, m_valid_q;
  logic [NODE_W-1:0]         n1_q, n2_q, n3_q, m_node_q;
  term_t [TERMS-1:0]         s1_d, s1_q;
  prod_t [TERMS-1:0]         s2_q;
  full_t [TERMS-1:0]         s3_q;
  logic signed [OUT_W-1:0]   m_val_q, m_dx_q, m_dy_q;

  logic signed [FACT_W-1:0]  xs, ys, mx, px, my, py;
  logic signed [FACT_W-1:0]  c0, c2, c4, c6, x2y, y2x_n, y2x, x2y_n;

  assign adv        = !m_valid_q || m_axis_tready;
  assign issue      = busy_q && adv;
  assign last_issue = issue && (cnt_q == N_LAST);
  assign s_axis_tready = !busy_q || last_issue;
  assign accept     = s_axis_tvalid && s_axis_tready;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (issue) begin
      cnt_d = cnt_q + NODE_W'(1);
    end
    if (last_issue) begin
      busy_d = 1'b0;
    end
    if (accept) begin
      busy_d = 1'b1;
      cnt_d  = N_FIRST;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= N_FIRST;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= clamp_coord(s_axis_tdata[15:0]);
      y_q <= clamp_coord(s_axis_tdata[31:16]);
    end
  end

  // factor select
  assign xs    = FACT_W'(x_q);
  assign ys    = FACT_W'(y_q);
  assign mx    = ONE - xs;
  assign px    = ONE + xs;
  assign my    = ONE - ys;
  assign py    = ONE + ys;
  assign c0    = ONE + xs + ys;
  assign c2    = ONE - xs + ys;
  assign c4    = ONE - xs - ys;
  assign c6    = ONE + xs - ys;
  assign x2y   = (xs <<< 1) + ys;      // 2x + y
  assign y2x_n = ys - (xs <<< 1);      // y - 2x
  assign y2x   = xs + (ys <<< 1);      // x + 2y
  assign x2y_n = (ys <<< 1) - xs;      // 2y - x

  always_comb begin
    unique case (cnt_q)
      N_SW: begin
        s1_d[0] = make_term(1'b1, 2'd2, mx, my, c0);
        s1_d[1] = make_term(1'b0, 2'd2, my, x2y, ONE);
        s1_d[2] = make_term(1'b0, 2'd2, mx, y2x, ONE);
      end
      N_S: begin
        s1_d[0] = make_term(1'b0, 2'd1, mx, px, my);
        s1_d[1] = make_term(1'b1, 2'd0, xs, my, ONE);
        s1_d[2] = make_term(1'b1, 2'd1, mx, px, ONE);
      end
      N_SE: begin
        s1_d[0] = make_term(1'b1, 2'd2, px, my, c2);
        s1_d[1] = make_term(1'b1, 2'd2, my, y2x_n, ONE);
        s1_d[2] = make_term(1'b0, 2'd2, px, x2y_n, ONE);
      end
      N_E: begin
        s1_d[0] = make_term(1'b0, 2'd1, px, py, my);
        s1_d[1] = make_term(1'b0, 2'd1, my, py, ONE);
        s1_d[2] = make_term(1'b1, 2'd0, ys, px, ONE);
      end
      N_NE: begin
        s1_d[0] = make_term(1'b1, 2'd2, px, py, c4);
        s1_d[1] = make_term(1'b0, 2'd2, py, x2y, ONE);
        s1_d[2] = make_term(1'b0, 2'd2, px, y2x, ONE);
      end
      N_N: begin
        s1_d[0] = make_term(1'b0, 2'd1, mx, px, py);
        s1_d[1] = make_term(1'b1, 2'd0, xs, py, ONE);
        s1_d[2] = make_term(1'b0, 2'd1, mx, px, ONE);
      end
      N_NW: begin
        s1_d[0] = make_term(1'b1, 2'd2, mx, py, c6);
        s1_d[1] = make_term(1'b1, 2'd2, py, y2x_n, ONE);
        s1_d[2] = make_term(1'b0, 2'd2, mx, x2y_n, ONE);
      end
      N_W: begin
        s1_d[0] = make_term(1'b0, 2'd1, mx, py, my);
        s1_d[1] = make_term(1'b1, 2'd1, my, py, ONE);
        s1_d[2] = make_term(1'b1, 2'd0, ys, mx, ONE);
      end
      default: begin
        s1_d = '0;
      end
    endcase
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q      <= issue;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      m_valid_q <= v3_q;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (adv) begin
      n1_q <= cnt_q;
      s1_q <= s1_d;
      n2_q <= n1_q;
      n3_q <= n2_q;
      m_node_q <= n3_q;
      for (int t = 0; t < TERMS; t++) begin
        s2_q[t].neg <= s1_q[t].neg;
        s2_q[t].k   <= s1_q[t].k;
        s2_q[t].p   <= PROD_W'(s1_q[t].ma) * PROD_W'(s1_q[t].mb);
        s2_q[t].mc  <= s1_q[t].mc;
        s3_q[t].neg <= s2_q[t].neg;
        s3_q[t].k   <= s2_q[t].k;
        s3_q[t].q   <= FULL_W'(s2_q[t].p) * FULL_W'(s2_q[t].mc);
      end
      m_val_q <= round_term(s3_q[0]);
      m_dx_q  <= round_term(s3_q[1]);
      m_dy_q  <= round_term(s3_q[2]);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'd0, m_dy_q, m_dx_q, m_val_q};
  assign m_axis_tuser  = m_node_q;
  assign m_axis_tlast  = (m_node_q == N_LAST);

  // a stalled stage keeps its transaction
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !adv |=> v3_q)
    else $error("stage 3 lost a transaction during a stall");

  a_cnt_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != N_FIRST |-> busy_q)
    else $error("node counter off start while idle");

  a_cnt_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue && cnt_q != N_LAST |=> busy_q && cnt_q == NODE_W'($past(cnt_q) + NODE_W'(1)))
    else $error("node sequencer skipped a node");

  a_node_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast && v3_q |=>
      m_axis_tvalid && m_axis_tuser == NODE_W'($past(m_axis_tuser) + NODE_W'(1)))
    else $error("results out of node order");

endmodule

### verif/quad8_shape_function_eval_top_tb.sv
// ----------------------------------------------------------------------------
// quad8_shape_function_eval_top_tb
// Drives points (xi, eta) into the Quad8 shape function evaluator and checks
// each node result against a bit-exact predictor of the shape functions.
// A directed table covers node positions, the element center and clamping.
// Random points follow, with random idle bursts on both streams, one long
// output hold-off and one full drain.
// ----------------------------------------------------------------------------
module quad8_shape_function_eval_top_tb;
  import q8sf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  RAND_POINTS  = 100;
  localparam int  STEADY_TAIL  = 20;
  localparam int  HOLD_CYCLES  = 80;
  localparam int  HOLD_AFTER   = 60;   // results seen before the long hold-off
  localparam int  DRAIN_AT     = 60;   // random point index that waits for a drain
  localparam int  TAIL_CYCLES  = 12;
  localparam time RUN_LIMIT    = 2_000_000ns;

  localparam logic signed [COORD_W-1:0] P1 = 16'sd16384;
  localparam logic signed [COORD_W-1:0] M1 = -16'sd16384;
  localparam logic signed [COORD_W-1:0] ZR = 16'sd0;
  localparam logic signed [OUT_W-1:0]   Q_ONE     = 17'sd16384;
  localparam logic signed [OUT_W-1:0]   Q_HALF    = 17'sd8192;
  localparam logic signed [OUT_W-1:0]   Q_NEG_QTR = -17'sd4096;

  typedef enum logic [1:0] {
    CHK_PRED,      // predictor only
    CHK_AT_NODE,   // shape values are 1.0 at one node and 0 elsewhere
    CHK_CENTER     // corners -0.25, midsides 0.5
  } check_e;

  typedef struct {
    logic signed [COORD_W-1:0] xi;
    logic signed [COORD_W-1:0] eta;
    check_e                    chk;
    logic [NODE_W-1:0]         node;
  } point_row_t;

  typedef struct packed {
    logic [NODE_W-1:0]       node;
    logic signed [OUT_W-1:0] shape;
    logic signed [OUT_W-1:0] dxi;
    logic signed [OUT_W-1:0] deta;
    logic                    last;
  } node_result_t;

  localparam int DIR_ROWS = 21;
  point_row_t dir_rows [DIR_ROWS] = '{
    '{M1, M1, CHK_AT_NODE, N_SW},
    '{ZR, M1, CHK_AT_NODE, N_S},
    '{P1, M1, CHK_AT_NODE, N_SE},
    '{P1, ZR, CHK_AT_NODE, N_E},
    '{P1, P1, CHK_AT_NODE, N_NE},
    '{ZR, P1, CHK_AT_NODE, N_N},
    '{M1, P1, CHK_AT_NODE, N_NW},
    '{M1, ZR, CHK_AT_NODE, N_W},
    '{ZR, ZR, CHK_CENTER,  N_SW},
    // coordinates beyond +-1.0 clamp onto the element boundary
    '{16'sh7FFF, 16'sh8000, CHK_AT_NODE, N_SE},
    '{16'sd16385, -16'sd16385, CHK_AT_NODE, N_SE},
    '{-16'sd20000, 16'sd20000, CHK_AT_NODE, N_NW},
    '{16'sd25000, ZR, CHK_AT_NODE, N_E},
    '{16'sh8000, 16'sh7FFF, CHK_AT_NODE, N_NW},
    '{16'sh7FFF, 16'sh7FFF, CHK_AT_NODE, N_NE},
    '{-16'sd1, 16'sd1, CHK_PRED, N_SW},
    '{16'sd16383, -16'sd16383, CHK_PRED, N_SW},
    '{-16'sd16383, 16'sd16383, CHK_PRED, N_SW},
    '{16'sh5555, 16'sh2AAA, CHK_PRED, N_SW},
    '{16'sh1555, -16'sd10923, CHK_PRED, N_SW},
    '{16'sd8192, -16'sd8192, CHK_PRED, N_SW}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;    // xi_coord[15:0], eta_coord[31:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;         // shape_value[16:0], deriv_xi[33:17],
                                     // deriv_eta[50:34], zero fill
  logic [2:0]  m_axis_tuser;         // node_index[2:0]
  logic        m_axis_tlast;

  node_result_t node_results_q [$];
  int           mismatch_cnt = 0;
  int           result_cnt   = 0;
  bit           steady       = 1'b0;

  quad8_shape_function_eval_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5ns clk_i = ~clk_i;

  initial begin : run_limit
    #(RUN_LIMIT);
    $display("quad8_shape_function_eval_top_tb failed");
    $finish;
  end

  function automatic longint clamp_coord_q(logic signed [COORD_W-1:0] v);
    longint w;
    w = longint'(v);
    if (w > 16384) return 16384;
    if (w < -16384) return -16384;
    return w;
  endfunction

  // sign * a * b * c / 2^(2*frac + k), rounded half away from zero, saturated
  function automatic logic signed [OUT_W-1:0] round_product(
    bit neg, int k, longint a, longint b, longint c
  );
    bit              s;
    longint unsigned p;
    longint unsigned r;
    int              sh;
    s  = neg ^ (a < 0) ^ (b < 0) ^ (c < 0);
    p  = longint'(a < 0 ? -a : a) * longint'(b < 0 ? -b : b)
       * longint'(c < 0 ? -c : c);
    sh = 2 * FRAC_BITS + k;
    r  = (p + (64'd1 << (sh - 1))) >> sh;
    if (s) begin
      if (r > 65536) r = 65536;
      return OUT_W'(-longint'(r));
    end
    if (r > 65535) r = 65535;
    return OUT_W'(r);
  endfunction

  function automatic void queue_node_results(
    logic signed [COORD_W-1:0] xi_raw, logic signed [COORD_W-1:0] eta_raw,
    check_e chk, logic [NODE_W-1:0] at_node
  );
    longint                  one, x, y, mx, px, my, py;
    logic signed [OUT_W-1:0] val [8];
    logic signed [OUT_W-1:0] dx  [8];
    logic signed [OUT_W-1:0] dy  [8];
    node_result_t            res;
    one = longint'(1) << FRAC_BITS;
    x   = clamp_coord_q(xi_raw);
    y   = clamp_coord_q(eta_raw);
    mx  = one - x;
    px  = one + x;
    my  = one - y;
    py  = one + y;

    val[N_SW] = round_product(1, 2, mx, my, one + x + y);
    val[N_S]  = round_product(0, 1, mx, px, my);
    val[N_SE] = round_product(1, 2, px, my, one - x + y);
    val[N_E]  = round_product(0, 1, px, py, my);
    val[N_NE] = round_product(1, 2, px, py, one - x - y);
    val[N_N]  = round_product(0, 1, mx, px, py);
    val[N_NW] = round_product(1, 2, mx, py, one + x - y);
    val[N_W]  = round_product(0, 1, mx, py, my);

    dx[N_SW] = round_product(0, 2, my, 2 * x + y, one);
    dx[N_S]  = round_product(1, 0, x, my, one);
    dx[N_SE] = round_product(1, 2, my, y - 2 * x, one);
    dx[N_E]  = round_product(0, 1, my, py, one);
    dx[N_NE] = round_product(0, 2, py, 2 * x + y, one);
    dx[N_N]  = round_product(1, 0, x, py, one);
    dx[N_NW] = round_product(1, 2, py, y - 2 * x, one);
    dx[N_W]  = round_product(1, 1, my, py, one);

    dy[N_SW] = round_product(0, 2, mx, x + 2 * y, one);
    dy[N_S]  = round_product(1, 1, mx, px, one);
    dy[N_SE] = round_product(0, 2, px, 2 * y - x, one);
    dy[N_E]  = round_product(1, 0, y, px, one);
    dy[N_NE] = round_product(0, 2, px, x + 2 * y, one);
    dy[N_N]  = round_product(0, 1, mx, px, one);
    dy[N_NW] = round_product(0, 2, mx, 2 * y - x, one);
    dy[N_W]  = round_product(1, 0, y, mx, one);

    for (int n = 0; n < 8; n++) begin
      res.node  = NODE_W'(n);
      res.shape = val[n];
      res.dxi   = dx[n];
      res.deta  = dy[n];
      res.last  = (NODE_W'(n) == N_LAST);
      // known values override the predictor where they are obvious
      if (chk == CHK_AT_NODE) begin
        res.shape = (NODE_W'(n) == at_node) ? Q_ONE : '0;
      end else if (chk == CHK_CENTER) begin
        res.shape = n[0] ? Q_HALF : Q_NEG_QTR;
      end
      node_results_q.push_back(res);
    end
  endfunction

  task automatic flag_mismatch(string what, int exp_v, int got_v);
    mismatch_cnt++;
    $display("[%0t] mismatch %s: expected %0d, got %0d", $time, what, exp_v, got_v);
  endtask

  // one point transaction, with an optional idle burst ahead of it
  task automatic send_point(
    logic signed [COORD_W-1:0] xi, logic signed [COORD_W-1:0] eta,
    check_e chk, logic [NODE_W-1:0] at_node
  );
    if (!steady && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {eta, xi};
    do @(posedge clk_i); while (!s_axis_tready);
    queue_node_results(xi, eta, chk, at_node);
    @(negedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    node_result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_cnt++;
      if (node_results_q.size() == 0) begin
        flag_mismatch("node_index of a transaction with none pending", -1,
                      int'(m_axis_tuser));
      end else begin
        e = node_results_q.pop_front();
        if (m_axis_tuser !== e.node)
          flag_mismatch("node_index", int'(e.node), int'(m_axis_tuser));
        if (m_axis_tdata[16:0] !== e.shape)
          flag_mismatch($sformatf("shape_value node %0d", e.node), int'(e.shape),
                        int'($signed(m_axis_tdata[16:0])));
        if (m_axis_tdata[33:17] !== e.dxi)
          flag_mismatch($sformatf("deriv_xi node %0d", e.node), int'(e.dxi),
                        int'($signed(m_axis_tdata[33:17])));
        if (m_axis_tdata[50:34] !== e.deta)
          flag_mismatch($sformatf("deriv_eta node %0d", e.node), int'(e.deta),
                        int'($signed(m_axis_tdata[50:34])));
        if (m_axis_tlast !== e.last)
          flag_mismatch($sformatf("last_node node %0d", e.node), int'(e.last),
                        int'(m_axis_tlast));
      end
    end
  end

  // result receiver: random stalls plus one long hold-off
  initial begin : result_sink
    bit hold_done;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && result_cnt >= HOLD_AFTER) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (!steady && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : point_source
    logic signed [COORD_W-1:0] rx;
    logic signed [COORD_W-1:0] ry;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_point(dir_rows[i].xi, dir_rows[i].eta, dir_rows[i].chk, dir_rows[i].node);
    end

    for (int i = 0; i < RAND_POINTS; i++) begin
      if (i == DRAIN_AT) begin
        s_axis_tvalid <= 1'b0;
        while (node_results_q.size() != 0) @(negedge clk_i);
      end
      if (i == RAND_POINTS - STEADY_TAIL) steady = 1'b1;
      // mostly inside the element, some raw codes that need clamping
      if ($urandom_range(0, 9) == 0) begin
        rx = COORD_W'($urandom_range(0, 65535));
        ry = COORD_W'($urandom_range(0, 65535));
      end else begin
        rx = COORD_W'(int'($urandom_range(0, 32768)) - 16384);
        ry = COORD_W'(int'($urandom_range(0, 32768)) - 16384);
      end
      send_point(rx, ry, CHK_PRED, N_FIRST);
    end
    s_axis_tvalid <= 1'b0;

    while (node_results_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("quad8_shape_function_eval_top_tb passed");
    end else begin
      $display("quad8_shape_function_eval_top_tb failed");
    end
    $finish;
  end

endmodule
